@@ rtl/core/tgr_pkg.sv @@
// Shared types and constants for the touch gesture recognizer.
// No dependencies; used by the top level and its checker.
package tgr_pkg;

  // APB address: eight registers, one 32-bit word each at byte offsets 4*i
  localparam int ADDR_W = 5;
  localparam int RAD_W  = 12;
  localparam int MS_W   = 16;
  localparam int RSQ_W  = 2 * RAD_W;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_DOWN = 2'd1,
    FUNC_MOVE = 2'd2,
    FUNC_UP   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_LONG_PRESS  = 3'd0,
    REG_TAP_MAX     = 3'd1,
    REG_TAP_CONFIRM = 3'd2,
    REG_DOUBLE_GAP  = 3'd3,
    REG_DOUBLE_RAD  = 3'd4,
    REG_DRAG_RAD    = 3'd5,
    REG_SWIPE_RAD   = 3'd6,
    REG_TAP_RAD     = 3'd7
  } reg_idx_t;

  localparam logic [2:0] G_NONE   = 3'd0;
  localparam logic [2:0] G_LONG   = 3'd1;
  localparam logic [2:0] G_SINGLE = 3'd2;
  localparam logic [2:0] G_DOUBLE = 3'd3;
  localparam logic [2:0] G_SWIPE  = 3'd4;

  // register reset values
  localparam logic [MS_W-1:0]  RST_LONG_PRESS  = 16'd500;
  localparam logic [MS_W-1:0]  RST_TAP_MAX     = 16'd300;
  localparam logic [MS_W-1:0]  RST_TAP_CONFIRM = 16'd300;
  localparam logic [MS_W-1:0]  RST_DOUBLE_GAP  = 16'd300;
  localparam logic [RAD_W-1:0] RST_DOUBLE_RAD  = 12'd100;
  localparam logic [RAD_W-1:0] RST_DRAG_RAD    = 12'd50;
  localparam logic [RAD_W-1:0] RST_SWIPE_RAD   = 12'd150;
  localparam logic [RAD_W-1:0] RST_TAP_RAD     = 12'd50;

  // squared radii, kept alongside the radii
  localparam logic [RSQ_W-1:0] RST_DOUBLE_SQ = 24'd10000;
  localparam logic [RSQ_W-1:0] RST_DRAG_SQ   = 24'd2500;
  localparam logic [RSQ_W-1:0] RST_SWIPE_SQ  = 24'd22500;
  localparam logic [RSQ_W-1:0] RST_TAP_SQ    = 24'd2500;

endpackage

@@ rtl/core/touch_gesture_recognizer.sv @@
// Touch gesture recognizer: one touch tracked, gestures from down/move/up/tick items.
// Depends on tgr_pkg. Checked by tgr_checker (bound in its own file).
//
// Usage:
//   Input channel (in_valid/in_ready): one item per event, func selects tick,
//   down, move or up; pos_x/pos_y are pixels, time_ms a wrapping ms stamp.
//   Output channel (out_valid/out_ready): exactly one item per input item,
//   gesture = none, long press, single tap, double tap or swipe.
//   The result is registered in the output register on the edge after
//   the input item is taken. Throughput is one item per cycle while no
//   stall holds it, set by the single pass through the distance unit (two
//   differences, two squarers, one add and compare) to the result register.
//   A stalled receiver holds the output register; in_ready stays high as
//   long as the register is empty or is being emptied in the same cycle.
//   Reset (rst, synchronous) clears the touch state, the pending tap, the
//   output register, and loads the default timing and radius registers.
//   Configuration: APB writes at byte offset 4*i, no wait states, pready
//   tied high. Write only while no item is in flight.
module touch_gesture_recognizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tgr_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // event items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  input  logic [COORD_BITS-1:0]         pos_x,
  input  logic [COORD_BITS-1:0]         pos_y,
  input  logic [31:0]                   time_ms,
  // gesture items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    gesture
);
  import tgr_pkg::*;

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int D2_W  = SQ_W + 1;
  localparam int CMP_W = (D2_W > RSQ_W) ? D2_W : RSQ_W;

  // ---------------- configuration registers ----------------
  logic [MS_W-1:0]  long_press_ms, tap_max_ms, tap_confirm_ms, double_gap_ms;
  logic [RAD_W-1:0] double_radius, drag_radius, swipe_radius, tap_radius;
  logic [RSQ_W-1:0] double_sq, drag_sq, swipe_sq, tap_sq;

  logic             cfg_we;
  reg_idx_t         cfg_idx;
  logic [RAD_W-1:0] wr_rad;
  logic [RSQ_W-1:0] wr_sq;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_rad  = pwdata[RAD_W-1:0];
  // one squarer shared by all radius writes; the square is kept in a register
  assign wr_sq   = RSQ_W'(wr_rad) * RSQ_W'(wr_rad);

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms  <= RST_LONG_PRESS;
      tap_max_ms     <= RST_TAP_MAX;
      tap_confirm_ms <= RST_TAP_CONFIRM;
      double_gap_ms  <= RST_DOUBLE_GAP;
      double_radius  <= RST_DOUBLE_RAD;
      drag_radius    <= RST_DRAG_RAD;
      swipe_radius   <= RST_SWIPE_RAD;
      tap_radius     <= RST_TAP_RAD;
      double_sq      <= RST_DOUBLE_SQ;
      drag_sq        <= RST_DRAG_SQ;
      swipe_sq       <= RST_SWIPE_SQ;
      tap_sq         <= RST_TAP_SQ;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_LONG_PRESS:  long_press_ms  <= pwdata[MS_W-1:0];
        REG_TAP_MAX:     tap_max_ms     <= pwdata[MS_W-1:0];
        REG_TAP_CONFIRM: tap_confirm_ms <= pwdata[MS_W-1:0];
        REG_DOUBLE_GAP:  double_gap_ms  <= pwdata[MS_W-1:0];
        REG_DOUBLE_RAD: begin
          double_radius <= wr_rad;
          double_sq     <= wr_sq;
        end
        REG_DRAG_RAD: begin
          drag_radius <= wr_rad;
          drag_sq     <= wr_sq;
        end
        REG_SWIPE_RAD: begin
          swipe_radius <= wr_rad;
          swipe_sq     <= wr_sq;
        end
        REG_TAP_RAD: begin
          tap_radius <= wr_rad;
          tap_sq     <= wr_sq;
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LONG_PRESS:  prdata = 32'(long_press_ms);
      REG_TAP_MAX:     prdata = 32'(tap_max_ms);
      REG_TAP_CONFIRM: prdata = 32'(tap_confirm_ms);
      REG_DOUBLE_GAP:  prdata = 32'(double_gap_ms);
      REG_DOUBLE_RAD:  prdata = 32'(double_radius);
      REG_DRAG_RAD:    prdata = 32'(drag_radius);
      REG_SWIPE_RAD:   prdata = 32'(swipe_radius);
      REG_TAP_RAD:     prdata = 32'(tap_radius);
    endcase
  end

  // ---------------- touch state ----------------
  logic                  touching, dragging, long_seen, double_seen, tap_pending;
  logic [COORD_BITS-1:0] start_x, start_y, tap_x, tap_y;
  logic [31:0]           start_time, tap_time;

  logic touching_next, dragging_next, long_seen_next, double_seen_next;
  logic tap_pending_next;
  logic start_load, tap_load;
  logic [2:0] gesture_next;

  logic in_acc;
  assign in_ready = !rst && (!out_valid || out_ready);
  assign in_acc   = in_valid && in_ready;

  // ---------------- distance unit ----------------
  // down measures against the pending tap point, all else against the start
  logic [COORD_BITS-1:0] ref_x, ref_y, dx, dy;
  logic [SQ_W-1:0]       dx2, dy2;
  logic [D2_W-1:0]       d2;
  logic [CMP_W-1:0]      d2c;
  logic [31:0]           el_start, el_tap;

  assign ref_x = (func == FUNC_DOWN) ? tap_x : start_x;
  assign ref_y = (func == FUNC_DOWN) ? tap_y : start_y;
  assign dx    = (pos_x >= ref_x) ? (pos_x - ref_x) : (ref_x - pos_x);
  assign dy    = (pos_y >= ref_y) ? (pos_y - ref_y) : (ref_y - pos_y);
  assign dx2   = SQ_W'(dx) * SQ_W'(dx);
  assign dy2   = SQ_W'(dy) * SQ_W'(dy);
  assign d2    = D2_W'(dx2) + D2_W'(dy2);
  assign d2c   = CMP_W'(d2);

  // elapsed times, modulo 2^32
  assign el_start = time_ms - start_time;
  assign el_tap   = time_ms - tap_time;

  always_comb begin
    touching_next    = touching;
    dragging_next    = dragging;
    long_seen_next   = long_seen;
    double_seen_next = double_seen;
    tap_pending_next = tap_pending;
    start_load       = 1'b0;
    tap_load         = 1'b0;
    gesture_next     = G_NONE;
    unique case (func)
      FUNC_TICK: begin
        if (touching && !dragging && !long_seen && !double_seen &&
            el_start > 32'(long_press_ms)) begin
          long_seen_next = 1'b1;
          gesture_next   = G_LONG;
        end else if (tap_pending && !double_seen &&
                     el_tap > 32'(tap_confirm_ms)) begin
          tap_pending_next = 1'b0;
          gesture_next     = G_SINGLE;
        end
      end
      FUNC_DOWN: begin
        start_load       = 1'b1;
        touching_next    = 1'b1;
        dragging_next    = 1'b0;
        long_seen_next   = 1'b0;
        double_seen_next = 1'b0;
        tap_pending_next = 1'b0;
        if (tap_pending && el_tap < 32'(double_gap_ms) &&
            d2c < CMP_W'(double_sq)) begin
          double_seen_next = 1'b1;
          gesture_next     = G_DOUBLE;
        end
      end
      FUNC_MOVE: begin
        if (d2c > CMP_W'(drag_sq)) dragging_next = 1'b1;
      end
      FUNC_UP: begin
        touching_next = 1'b0;
        dragging_next = 1'b0;
        if (!double_seen && !long_seen) begin
          if (dragging && d2c > CMP_W'(swipe_sq)) begin
            gesture_next = G_SWIPE;
          end else if (el_start < 32'(tap_max_ms) && d2c < CMP_W'(tap_sq)) begin
            tap_pending_next = 1'b1;
            tap_load         = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touching    <= 1'b0;
      dragging    <= 1'b0;
      long_seen   <= 1'b0;
      double_seen <= 1'b0;
      tap_pending <= 1'b0;
      start_x     <= '0;
      start_y     <= '0;
      start_time  <= '0;
      tap_x       <= '0;
      tap_y       <= '0;
      tap_time    <= '0;
    end else if (in_acc) begin
      touching    <= touching_next;
      dragging    <= dragging_next;
      long_seen   <= long_seen_next;
      double_seen <= double_seen_next;
      tap_pending <= tap_pending_next;
      if (start_load) begin
        start_x    <= pos_x;
        start_y    <= pos_y;
        start_time <= time_ms;
      end
      if (tap_load) begin
        tap_x    <= pos_x;
        tap_y    <= pos_y;
        tap_time <= time_ms;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) gesture <= gesture_next;
  end

endmodule

@@ rtl/core/tgr_checker.sv @@
// Port-level checks for the touch gesture recognizer, bound to the top level.
// Depends on tgr_pkg.
module tgr_checker (
  input logic       clk,
  input logic       rst,
  input logic       pready,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] func,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] gesture
);
  import tgr_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(gesture))
    else $error("stalled gesture item changed");

  // every accepted item yields a result on the next edge
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // move never reports a gesture
  a_move_none: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_MOVE |=> gesture == G_NONE)
    else $error("move item reported a gesture");

  // tick reports only none, long press or single tap
  a_tick_codes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_TICK |=>
      gesture == G_NONE || gesture == G_LONG || gesture == G_SINGLE)
    else $error("tick item reported a touch-only gesture");

  // up reports only none or swipe
  a_up_codes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_UP && pready |=>
      gesture == G_NONE || gesture == G_SWIPE)
    else $error("up item reported a wrong gesture");

endmodule

bind touch_gesture_recognizer tgr_checker u_tgr_checker (.*);
